// File: hdl/usbmtx_pkg.sv
package usbmtx_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_SEND     = 2'd0;
  localparam logic [1:0] REQ_COMPLETE = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // link status codes
  localparam logic [1:0] LINK_UNKNOWN      = 2'd0;
  localparam logic [1:0] LINK_CONNECTED    = 2'd1;
  localparam logic [1:0] LINK_DISCONNECTED = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  // configuration register indexes
  localparam logic CFG_IN_ENDPOINT   = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

  localparam logic [3:0] IN_ENDPOINT_RESET   = 4'd1;
  localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX           = 8'hFF;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_WORD,
    ST_STATUS
  } ctl_state_t;

  // one result beat handed from the controller to the output register
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              accepted;
    logic [1:0]        link;
    logic              changed;
    logic              flushed;
  } emit_t;

endpackage

// File: hdl/usb_midi_tx_event_queue.sv
// USB-MIDI IN-endpoint event queue. Send requests have their code index nibble
// replaced by the status nibble and go into a ring of QUEUE_DEPTH words held in
// one synchronous RAM (at most QUEUE_DEPTH-1 in flight; a full ring answers
// with accepted clear). Every input gives any batch words it releases, oldest
// first, then one status beat with last set. An input is taken in ST_IDLE and
// executed in ST_EXEC; each released word is read in ST_READ and given in
// ST_WORD, then the status beat in ST_STATUS; an output stall holds either.
// A new input is taken as soon as the status beat sits in the output register.
// The RAM is never cleared; the pointers ensure only written entries are read.
module usb_midi_tx_event_queue
  import usbmtx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [WORD_W-1:0] event_word,
  input  logic [3:0]        endpoint,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [WORD_W-1:0] packet_word,
  output logic              last,
  output logic              accepted,
  output logic [1:0]        link_state,
  output logic              link_changed,
  output logic              flushed
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  emit_t             emit;
  logic              emit_free;

  // queue store
  usbmtx_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request sequencer and queue pointers
  usbmtx_ctl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW)
  ) u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .event_word (event_word),
    .endpoint   (endpoint),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .emit       (emit),
    .emit_free  (emit_free)
  );

  // result beat register
  usbmtx_out u_out (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .emit_free    (emit_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .packet_word  (packet_word),
    .last         (last),
    .accepted     (accepted),
    .link_state   (link_state),
    .link_changed (link_changed),
    .flushed      (flushed)
  );

endmodule

// File: hdl/usbmtx_ram.sv
module usbmtx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/usbmtx_out.sv
module usbmtx_out
  import usbmtx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  emit_t             emit,
  output logic              emit_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [WORD_W-1:0] packet_word,
  output logic              last,
  output logic              accepted,
  output logic [1:0]        link_state,
  output logic              link_changed,
  output logic              flushed
);

  assign emit_free = !out_valid || out_ready;

  // hold the beat until taken, load a new one when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_free) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_free && emit.valid) begin
      kind         <= emit.kind;
      packet_word  <= emit.word;
      last         <= emit.last;
      accepted     <= emit.accepted;
      link_state   <= emit.link;
      link_changed <= emit.changed;
      flushed      <= emit.flushed;
    end
  end

endmodule

// File: hdl/usbmtx_ctl.sv
module usbmtx_ctl
  import usbmtx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [WORD_W-1:0] event_word,
  input  logic [3:0]        endpoint,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              ram_we,
  output logic [IW-1:0]     ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic [IW-1:0]     ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata,
  output emit_t             emit,
  input  logic              emit_free
);

  localparam logic [IW-1:0] LAST_INDEX = IW'(QUEUE_DEPTH - 1);

  ctl_state_t state, state_next;

  logic [1:0]        req;
  logic [WORD_W-1:0] word;
  logic [3:0]        ep;

  logic [3:0]    in_endpoint;
  logic [7:0]    timeout_limit;
  logic [IW-1:0] write_index, write_index_next;
  logic [IW-1:0] read_index, read_index_next;
  logic          tx_busy, tx_busy_next;
  logic [7:0]    timeout_count, timeout_count_next;
  logic [1:0]    link_status, link_status_next;
  logic          acc, acc_next;
  logic          changed, changed_next;
  logic          flush, flush_next;
  logic          start_batch;

  logic [IW-1:0] wr_inc;
  logic [IW-1:0] rd_inc;
  logic [7:0]    count_inc;

  assign wr_inc    = (write_index == LAST_INDEX) ? '0 : write_index + 1'b1;
  assign rd_inc    = (read_index == LAST_INDEX) ? '0 : read_index + 1'b1;
  assign count_inc = (timeout_count == COUNT_MAX) ? timeout_count : timeout_count + 8'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_endpoint   <= IN_ENDPOINT_RESET;
      timeout_limit <= TIMEOUT_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IN_ENDPOINT:   in_endpoint   <= cfg_data[3:0];
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req  <= req_type;
      word <= event_word;
      ep   <= endpoint;
    end
  end

  // execute the request and advance the drain
  always_comb begin
    write_index_next   = write_index;
    read_index_next    = read_index;
    tx_busy_next       = tx_busy;
    timeout_count_next = timeout_count;
    link_status_next   = link_status;
    acc_next           = acc;
    changed_next       = changed;
    flush_next         = flush;
    start_batch        = 1'b0;
    case (state)
      ST_EXEC: begin
        acc_next     = 1'b0;
        changed_next = 1'b0;
        flush_next   = 1'b0;
        case (req)
          REQ_SEND: begin
            if (wr_inc != read_index) begin
              write_index_next = wr_inc;
              acc_next         = 1'b1;
              start_batch      = !tx_busy;
            end
          end
          REQ_COMPLETE: begin
            if (ep == in_endpoint) begin
              tx_busy_next       = 1'b0;
              timeout_count_next = '0;
              if (link_status != LINK_CONNECTED) begin
                link_status_next = LINK_CONNECTED;
                changed_next     = 1'b1;
              end
              start_batch = (read_index != write_index);
            end
          end
          REQ_TICK: begin
            if (tx_busy) begin
              timeout_count_next = count_inc;
              if (count_inc > timeout_limit) begin
                read_index_next = write_index;
                tx_busy_next    = 1'b0;
                flush_next      = 1'b1;
              end
              if (link_status != LINK_DISCONNECTED) begin
                link_status_next = LINK_DISCONNECTED;
                changed_next     = 1'b1;
              end
            end
          end
          default: ;
        endcase
        if (start_batch) begin
          tx_busy_next = 1'b1;
        end
      end
      ST_WORD: begin
        if (emit_free) begin
          read_index_next = rd_inc;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = start_batch ? ST_READ : ST_STATUS;
      ST_READ: state_next = ST_WORD;
      ST_WORD: begin
        if (emit_free) begin
          state_next = (rd_inc == write_index) ? ST_STATUS : ST_READ;
        end
      end
      ST_STATUS: begin
        if (emit_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake, memory access, result beats
  always_comb begin
    in_ready      = (state == ST_IDLE);
    ram_we        = (state == ST_EXEC) && (req == REQ_SEND) && (wr_inc != read_index);
    ram_waddr     = write_index;
    ram_wdata     = {word[WORD_W-1:4], word[15:12]};
    ram_raddr     = read_index;
    emit          = '0;
    case (state)
      ST_WORD: begin
        emit.valid = 1'b1;
        emit.kind  = KIND_WORD;
        emit.word  = ram_rdata;
      end
      ST_STATUS: begin
        emit.valid    = 1'b1;
        emit.kind     = KIND_STATUS;
        emit.last     = 1'b1;
        emit.accepted = acc;
        emit.link     = link_status;
        emit.changed  = changed;
        emit.flushed  = flush;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_index   <= '0;
      read_index    <= '0;
      tx_busy       <= 1'b0;
      timeout_count <= '0;
      link_status   <= LINK_UNKNOWN;
      acc           <= 1'b0;
      changed       <= 1'b0;
      flush         <= 1'b0;
    end else begin
      state         <= state_next;
      write_index   <= write_index_next;
      read_index    <= read_index_next;
      tx_busy       <= tx_busy_next;
      timeout_count <= timeout_count_next;
      link_status   <= link_status_next;
      acc           <= acc_next;
      changed       <= changed_next;
      flush         <= flush_next;
    end
  end

endmodule
